// ----- rtl/core/ycbcr_quad_to_rgb_top_defines.svh -----
// Assertion macros shared by the checker of the color conversion block.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef YCBCR_QUAD_TO_RGB_TOP_DEFINES_SVH
`define YCBCR_QUAD_TO_RGB_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define YCQ_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define YCQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/ycq_pkg.sv -----
// Types and constants of the YCbCr quad to RGB converter.
// No dependencies; every other file of the block but the assertion macros header uses it.
package ycq_pkg;

    localparam int PROD_W = 26;
    localparam int SUM_W  = 28;

    localparam logic signed [17:0] COEF_CR_R = 18'sd91881;
    localparam logic signed [17:0] COEF_CB_G = 18'sd22553;
    localparam logic signed [17:0] COEF_CR_G = 18'sd46802;
    localparam logic signed [17:0] COEF_CB_B = 18'sd116130;
    localparam logic [SUM_W-1:0]   HALF_Q16  = SUM_W'(32768);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SUB_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUB_H = 2'd1;

    localparam logic [CFG_DAT_W-1:0] SUB_RESET = 2'd2;

    typedef struct packed {
        logic [7:0] luma_tl;
        logic [7:0] luma_tr;
        logic [7:0] luma_bl;
        logic [7:0] luma_br;
        logic [7:0] blue_diff_a;
        logic [7:0] blue_diff_b;
        logic [7:0] blue_diff_c;
        logic [7:0] blue_diff_d;
        logic [7:0] red_diff_a;
        logic [7:0] red_diff_b;
        logic [7:0] red_diff_c;
        logic [7:0] red_diff_d;
    } req_t;

    typedef struct packed {
        logic [7:0] tl_red;
        logic [7:0] tl_green;
        logic [7:0] tl_blue;
        logic [7:0] tr_red;
        logic [7:0] tr_green;
        logic [7:0] tr_blue;
        logic [7:0] bl_red;
        logic [7:0] bl_green;
        logic [7:0] bl_blue;
        logic [7:0] br_red;
        logic [7:0] br_green;
        logic [7:0] br_blue;
    } rsp_t;

    typedef struct packed {
        logic half_w;
        logic half_h;
    } sub_cfg_t;

    typedef struct packed {
        logic [7:0]        luma;
        logic signed [7:0] db;
        logic signed [7:0] dr;
    } pix_t;

    typedef pix_t [3:0] pix_quad_t;

    typedef struct packed {
        logic [7:0]               luma;
        logic signed [PROD_W-1:0] cr_r;
        logic signed [PROD_W-1:0] cb_g;
        logic signed [PROD_W-1:0] cr_g;
        logic signed [PROD_W-1:0] cb_b;
    } prod_t;

    typedef prod_t [3:0] prod_quad_t;

endpackage

// ----- rtl/core/ycq_sel_stage.sv -----
// First pipeline stage: picks the chroma pair of each pixel and removes the chroma offset.
// Depends on ycq_pkg.
module ycq_sel_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  ycq_pkg::sub_cfg_t cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  ycq_pkg::req_t     in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output ycq_pkg::pix_quad_t out_data
);
    import ycq_pkg::*;

    logic      valid_reg;
    pix_quad_t data_reg;
    pix_quad_t data_next;
    logic      advance;

    logic [3:0][7:0] cb;
    logic [3:0][7:0] cr;
    logic [3:0][7:0] luma;

    assign advance  = !valid_reg || !out_stall;
    assign in_stall = !advance;

    assign cb   = {in_data.blue_diff_d, in_data.blue_diff_c,
                   in_data.blue_diff_b, in_data.blue_diff_a};
    assign cr   = {in_data.red_diff_d, in_data.red_diff_c,
                   in_data.red_diff_b, in_data.red_diff_a};
    assign luma = {in_data.luma_br, in_data.luma_bl,
                   in_data.luma_tr, in_data.luma_tl};

    // Pixel p sits at row p[1] and column p[0]; subsampling drops the matching index bit.
    always_comb
    begin
        logic [1:0] idx;
        for (int p = 0; p < 4; p++)
        begin
            idx = {p[1] & ~cfg.half_h, p[0] & ~cfg.half_w};
            data_next[p].luma = luma[p];
            data_next[p].db   = $signed({~cb[idx][7], cb[idx][6:0]});
            data_next[p].dr   = $signed({~cr[idx][7], cr[idx][6:0]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/core/ycq_mul_stage.sv -----
// Second pipeline stage: forms the four Q16 chroma products of every pixel.
// Depends on ycq_pkg.
module ycq_mul_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ycq_pkg::pix_quad_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ycq_pkg::prod_quad_t out_data
);
    import ycq_pkg::*;

    logic       valid_reg;
    prod_quad_t data_reg;
    prod_quad_t data_next;
    logic       advance;

    assign advance  = !valid_reg || !out_stall;
    assign in_stall = !advance;

    always_comb
    begin
        for (int p = 0; p < 4; p++)
        begin
            data_next[p].luma = in_data[p].luma;
            data_next[p].cr_r = PROD_W'(COEF_CR_R * in_data[p].dr);
            data_next[p].cb_g = PROD_W'(COEF_CB_G * in_data[p].db);
            data_next[p].cr_g = PROD_W'(COEF_CR_G * in_data[p].dr);
            data_next[p].cb_b = PROD_W'(COEF_CB_B * in_data[p].db);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/core/ycq_sum_stage.sv -----
// Last pipeline stage: adds luma and products, rounds, clamps and holds the response.
// Depends on ycq_pkg.
module ycq_sum_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  ycq_pkg::prod_quad_t in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output ycq_pkg::rsp_t       out_data
);
    import ycq_pkg::*;

    logic            valid_reg;
    rsp_t            data_reg;
    rsp_t            data_next;
    logic            advance;
    logic [3:0][7:0] red;
    logic [3:0][7:0] green;
    logic [3:0][7:0] blue;

    function automatic logic [SUM_W-1:0] ext(input logic signed [PROD_W-1:0] v);
        return {{(SUM_W-PROD_W){v[PROD_W-1]}}, v};
    endfunction

    // A negative sum gives zero; any bit above the eight result bits gives full scale.
    function automatic logic [7:0] clamp(input logic [SUM_W-1:0] t);
        logic [7:0] q;
        if (t[SUM_W-1])
        begin
            q = 8'd0;
        end
        else if (|t[SUM_W-2:24])
        begin
            q = 8'hFF;
        end
        else
        begin
            q = t[23:16];
        end
        return q;
    endfunction

    assign advance  = !valid_reg || !out_stall;
    assign in_stall = !advance;

    always_comb
    begin
        logic [SUM_W-1:0] yy;
        for (int p = 0; p < 4; p++)
        begin
            yy       = SUM_W'({in_data[p].luma, 16'h0000}) + HALF_Q16;
            red[p]   = clamp(yy + ext(in_data[p].cr_r));
            green[p] = clamp(yy - ext(in_data[p].cb_g) - ext(in_data[p].cr_g));
            blue[p]  = clamp(yy + ext(in_data[p].cb_b));
        end
        data_next.tl_red   = red[0];
        data_next.tl_green = green[0];
        data_next.tl_blue  = blue[0];
        data_next.tr_red   = red[1];
        data_next.tr_green = green[1];
        data_next.tr_blue  = blue[1];
        data_next.bl_red   = red[2];
        data_next.bl_green = green[2];
        data_next.bl_blue  = blue[2];
        data_next.br_red   = red[3];
        data_next.br_green = green[3];
        data_next.br_blue  = blue[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/core/ycbcr_quad_to_rgb_top.sv -----
// An accepted request passes the select, multiply and sum registers in turn, then appears as the response.
// Throughput: one request per cycle while nothing stalls; three register stages: select, multiply, sum.
// Every stage moves on when the stage after it is empty or moving, so a stall loses nothing.
// Reset clears all valid bits and sets both subsampling registers to two (4:2:0).
// Top level of the converter; depends on ycq_pkg and the three stage modules.
module ycbcr_quad_to_rgb_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  ycq_pkg::req_t                   req_data,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output ycq_pkg::rsp_t                   rsp_data,
    input  logic                            cfg_write,
    input  logic [ycq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ycq_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import ycq_pkg::*;

    logic [CFG_DAT_W-1:0] sub_w_reg;
    logic [CFG_DAT_W-1:0] sub_h_reg;
    sub_cfg_t             cfg;

    logic       sel_valid;
    logic       sel_stall;
    pix_quad_t  sel_data;
    logic       mul_valid;
    logic       mul_stall;
    prod_quad_t mul_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_w_reg <= SUB_RESET;
            sub_h_reg <= SUB_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SUB_W: sub_w_reg <= cfg_data;
                REG_SUB_H: sub_h_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // Values two and three both mean subsampling by two.
    assign cfg.half_w = sub_w_reg[1];
    assign cfg.half_h = sub_h_reg[1];

    ycq_sel_stage u_sel (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (req_valid),
        .in_stall  (req_stall),
        .in_data   (req_data),
        .out_valid (sel_valid),
        .out_stall (sel_stall),
        .out_data  (sel_data)
    );

    ycq_mul_stage u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sel_valid),
        .in_stall  (sel_stall),
        .in_data   (sel_data),
        .out_valid (mul_valid),
        .out_stall (mul_stall),
        .out_data  (mul_data)
    );

    ycq_sum_stage u_sum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mul_valid),
        .in_stall  (mul_stall),
        .in_data   (mul_data),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .out_data  (rsp_data)
    );

endmodule

// ----- rtl/core/ycq_checker.sv -----
// Port-level checks of the converter, attached to the top level by a bind.
// Depends on ycq_pkg and the assertion macros header.
`include "ycbcr_quad_to_rgb_top_defines.svh"

module ycq_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input ycq_pkg::rsp_t rsp_data
);

    logic req_taken;
    assign req_taken = req_valid && !req_stall;

    // A stalled response stays and keeps its value.
    `YCQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

    // Requests back up only when every stage is full and the response is stalled.
    `YCQ_ASSERT_IMPL(a_stall_cause, req_stall, rsp_valid && rsp_stall)

    // With the response side free, a taken request passes the select, multiply and sum registers and comes out.
    `YCQ_ASSERT_NEXT(a_latency, req_taken ##1 !rsp_stall ##1 !rsp_stall, rsp_valid)

endmodule

bind ycbcr_quad_to_rgb_top ycq_checker u_ycq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
);
